### rtl/hst_pkg.sv
// Shared types and constants for the hashed symbol table.
`default_nettype none

package hst_pkg;

    localparam int CAPACITY_DEF   = 256;
    localparam int ENTRY_BITS_DEF = 64;
    localparam int KEY_BITS       = 64;
    localparam int IDX_OUT_BITS   = 8;
    localparam int DATA_OUT_BITS  = 64;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_FIND   = 2'd1,
        CMD_READ   = 2'd2,
        CMD_CLEAR  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_NOT_FOUND = 2'd1,
        STAT_FULL      = 2'd2,
        STAT_RANGE     = 2'd3
    } status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_RUN  = 1'b1
    } state_t;

    // Control part of the token that walks down the cell row.
    typedef struct packed {
        logic valid;
        cmd_t op;
        logic hit;
    } tok_t;

endpackage

`default_nettype wire

### rtl/hst_cell.sv
// One table slot: stores a hash and an entry word and acts on the passing token.
`default_nettype none

module hst_cell
    import hst_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int ENTRY_BITS = ENTRY_BITS_DEF,
    parameter int CELL_IDX   = 0,
    localparam int IDX_W     = $clog2(CAPACITY),
    localparam int CNT_W     = $clog2(CAPACITY + 1)
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic [CNT_W-1:0]      count,
    input  wire tok_t                  tok_in,
    input  wire logic [KEY_BITS-1:0]   key_in,
    input  wire logic [ENTRY_BITS-1:0] data_in,
    input  wire logic [IDX_W-1:0]      idx_in,
    output tok_t                       tok_out,
    output logic [KEY_BITS-1:0]        key_out,
    output logic [ENTRY_BITS-1:0]      data_out,
    output logic [IDX_W-1:0]           idx_out
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);
    localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(CELL_IDX);

    tok_t                  tok_reg;
    tok_t                  tok_next;
    logic [KEY_BITS-1:0]   key_reg;
    logic [ENTRY_BITS-1:0] data_reg;
    logic [ENTRY_BITS-1:0] data_next;
    logic [IDX_W-1:0]      idx_reg;
    logic [IDX_W-1:0]      idx_next;
    logic [KEY_BITS-1:0]   hash_reg;
    logic [ENTRY_BITS-1:0] ent_reg;

    logic addr_hit;
    logic do_write;
    logic do_read;
    logic match;

    assign addr_hit = (idx_in == MY_IDX);
    assign do_write = tok_in.valid && (tok_in.op == CMD_INSERT) && addr_hit;
    assign do_read  = tok_in.valid && (tok_in.op == CMD_READ) && addr_hit;
    // Only slots below the fill count take part in a search.
    assign match    = tok_in.valid && (tok_in.op == CMD_FIND) && !tok_in.hit
                      && (MY_CNT < count) && (hash_reg == key_in);

    always_comb
    begin
        tok_next     = tok_in;
        tok_next.hit = tok_in.hit | match;
        data_next    = do_read ? ent_reg : data_in;
        idx_next     = match ? MY_IDX : idx_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg  <= key_in;
        data_reg <= data_next;
        idx_reg  <= idx_next;
    end

    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            hash_reg <= key_in;
            ent_reg  <= data_in;
        end
    end

    assign tok_out  = tok_reg;
    assign key_out  = key_reg;
    assign data_out = data_reg;
    assign idx_out  = idx_reg;

endmodule

`default_nettype wire

### rtl/hashed_symbol_table_unit.sv
// Top level: command decode, fill count, cell row and result register.
//
//   channel | direction | handshake             | beat fields
//   in      | input     | in_valid / in_stall   | command, key_hash, entry_data, entry_index
//   out     | output    | out_valid / out_stall | status, result_index, read_data
//
// Insert (with room), find and read (in range) send a token down the row of
// CAPACITY cells, registered in each cell, and the token leaving the last cell
// is registered into the result register; no new beat is taken while it is in the row.
// Clear, insert into a full table and a read out of range answer without a token.
// Reset empties the table at once; stored words need no clearing pass.
// in_stall is high while a token is in the row or the result register is held.
`default_nettype none

module hashed_symbol_table_unit
    import hst_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int ENTRY_BITS = ENTRY_BITS_DEF
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic [1:0]                 command,
    input  wire logic signed [KEY_BITS-1:0] key_hash,
    input  wire logic [63:0]                entry_data,
    input  wire logic [7:0]                 entry_index,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic [1:0]                      status,
    output logic [IDX_OUT_BITS-1:0]         result_index,
    output logic [DATA_OUT_BITS-1:0]        read_data
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > 9) ? CNT_W : 9;
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);

    state_t                   state_reg;
    state_t                   state_next;
    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    status_t                  status_reg;
    status_t                  status_next;
    logic [IDX_OUT_BITS-1:0]  rindex_reg;
    logic [IDX_OUT_BITS-1:0]  rindex_next;
    logic [DATA_OUT_BITS-1:0] rdata_reg;
    logic [DATA_OUT_BITS-1:0] rdata_next;

    tok_t                  tok_c  [CAPACITY+1];
    logic [KEY_BITS-1:0]   key_c  [CAPACITY+1];
    logic [ENTRY_BITS-1:0] data_c [CAPACITY+1];
    logic [IDX_W-1:0]      idx_c  [CAPACITY+1];

    cmd_t        cmd;
    logic        accept;
    logic        full;
    logic        rd_range;
    logic        dispatch;
    tok_t        tail;

    assign cmd        = cmd_t'(command);
    assign accept     = in_valid && !in_stall;
    assign full       = (count_reg >= CNT_FULL);
    assign rd_range   = (CMP_W'(entry_index) >= CMP_W'(count_reg));
    assign tail       = tok_c[CAPACITY];

    always_comb
    begin
        dispatch = 1'b0;
        case (cmd)
            CMD_INSERT: dispatch = !full;
            CMD_FIND:   dispatch = 1'b1;
            CMD_READ:   dispatch = !rd_range;
            CMD_CLEAR:  dispatch = 1'b0;
            default:    dispatch = 1'b0;
        endcase
    end

    // Head of the row.
    assign tok_c[0]  = '{valid: accept && dispatch, op: cmd, hit: 1'b0};
    assign key_c[0]  = key_hash;
    assign data_c[0] = ENTRY_BITS'(entry_data);
    assign idx_c[0]  = (cmd == CMD_INSERT) ? count_reg[IDX_W-1:0] :
                       (cmd == CMD_READ)   ? IDX_W'(entry_index) : '0;

    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        hst_cell #(
            .CAPACITY   (CAPACITY),
            .ENTRY_BITS (ENTRY_BITS),
            .CELL_IDX   (g)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .count    (count_reg),
            .tok_in   (tok_c[g]),
            .key_in   (key_c[g]),
            .data_in  (data_c[g]),
            .idx_in   (idx_c[g]),
            .tok_out  (tok_c[g+1]),
            .key_out  (key_c[g+1]),
            .data_out (data_c[g+1]),
            .idx_out  (idx_c[g+1])
        );
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && out_stall;
        status_next    = status_reg;
        rindex_next    = rindex_reg;
        rdata_next     = rdata_reg;
        in_stall       = (state_reg != S_IDLE) || (out_valid_reg && out_stall);

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (dispatch)
                    begin
                        state_next = S_RUN;
                        if (cmd == CMD_INSERT)
                        begin
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                    else
                    begin
                        // Answer at once: clear, full table or bad index.
                        out_valid_next = 1'b1;
                        rindex_next    = '0;
                        rdata_next     = '0;
                        case (cmd)
                            CMD_INSERT: status_next = STAT_FULL;
                            CMD_READ:   status_next = STAT_RANGE;
                            default:
                            begin
                                status_next = STAT_OK;
                                count_next  = '0;
                            end
                        endcase
                    end
                end
            end
            S_RUN:
            begin
                if (tail.valid)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                    status_next    = STAT_OK;
                    rindex_next    = '0;
                    rdata_next     = '0;
                    case (tail.op)
                        CMD_INSERT: rindex_next = IDX_OUT_BITS'(idx_c[CAPACITY]);
                        CMD_FIND:
                        begin
                            if (tail.hit)
                            begin
                                rindex_next = IDX_OUT_BITS'(idx_c[CAPACITY]);
                            end
                            else
                            begin
                                status_next = STAT_NOT_FOUND;
                            end
                        end
                        CMD_READ:   rdata_next = DATA_OUT_BITS'(data_c[CAPACITY]);
                        default:    status_next = STAT_OK;
                    endcase
                end
            end
            default:    state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        rindex_reg <= rindex_next;
        rdata_reg  <= rdata_next;
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign result_index = rindex_reg;
    assign read_data    = rdata_reg;

`ifndef SYNTHESIS
    a_tail_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        tail.valid |-> state_reg == S_RUN)
        else $error("token left the row while idle");

    a_tail_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        tail.valid |-> !out_valid_reg)
        else $error("row result arrived with result register occupied");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("fill count above capacity");

    a_dispatch_run: assert property (@(posedge clk) disable iff (!rst_n)
        tok_c[0].valid |=> state_reg == S_RUN)
        else $error("token sent without entering run state");
`endif

endmodule

`default_nettype wire

### bench/tb_hashed_symbol_table_unit.sv
// Self-checking testbench for the hashed symbol table unit.
module tb_hashed_symbol_table_unit;
    import hst_pkg::*;

    localparam int          TABLE_SIZE  = CAPACITY_DEF;
    localparam int          HOLD_CYCLES = 600;
    localparam int          TIME_LIMIT  = 10_000_000;
    localparam logic [63:0] KEY_MIN     = 64'h8000_0000_0000_0000;
    localparam logic [63:0] KEY_MAX     = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] ALL_ONES    = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct {
        status_t     st;
        logic [7:0]  idx;
        logic [63:0] word;
    } answer_t;

    logic clk = 1'b0;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic [1:0] command;
    logic signed [KEY_BITS-1:0] key_hash;
    logic [63:0] entry_data;
    logic [7:0] entry_index;
    logic out_valid;
    logic out_stall;
    logic [1:0] status;
    logic [IDX_OUT_BITS-1:0] result_index;
    logic [DATA_OUT_BITS-1:0] read_data;

    // Shadow copy of the table contents
    logic [8:0]  table_count;
    logic [63:0] key_table [TABLE_SIZE];
    logic [63:0] word_table [TABLE_SIZE];

    answer_t     answers_due [$];
    logic [63:0] seen_keys [$];
    int          bad_beats;
    bit          hold_req;
    bit          sender_quiet;
    bit          receiver_quiet;

    hashed_symbol_table_unit DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .command      (command),
        .key_hash     (key_hash),
        .entry_data   (entry_data),
        .entry_index  (entry_index),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .result_index (result_index),
        .read_data    (read_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic answer_t table_answer(input cmd_t op, input logic [63:0] key,
                                             input logic [63:0] word, input logic [7:0] idx);
        answer_t a;
        bit      hit;
        a.st   = STAT_OK;
        a.idx  = '0;
        a.word = '0;
        hit    = 1'b0;
        case (op)
            CMD_INSERT:
            begin
                if (table_count >= TABLE_SIZE)
                    a.st = STAT_FULL;
                else
                begin
                    key_table[table_count[7:0]]  = key;
                    word_table[table_count[7:0]] = word;
                    a.idx = table_count[7:0];
                    table_count = table_count + 1'b1;
                end
            end
            CMD_FIND:
            begin
                // lowest matching index wins
                for (int i = 0; i < table_count && !hit; i++)
                begin
                    if (key_table[i[7:0]] == key)
                    begin
                        hit   = 1'b1;
                        a.idx = i[7:0];
                    end
                end
                if (!hit)
                    a.st = STAT_NOT_FOUND;
            end
            CMD_READ:
            begin
                if (idx >= table_count)
                    a.st = STAT_RANGE;
                else
                    a.word = word_table[idx];
            end
            default:
                table_count = '0;
        endcase
        return a;
    endfunction

    task automatic flag_mismatch(input string msg);
        bad_beats++;
        if (bad_beats <= 10)
            $display("%0t mismatch: %s", $time, msg);
    endtask

    // Check result beats and predict every accepted command beat
    always @(posedge clk)
    begin : watch_channels
        answer_t due;
        if (rst_n === 1'b1)
        begin
            if (out_valid === 1'b1 && out_stall === 1'b0)
            begin
                if (answers_due.size() == 0)
                    flag_mismatch($sformatf("unexpected beat status %0d index %0d data %h",
                                            status, result_index, read_data));
                else
                begin
                    due = answers_due.pop_front();
                    if (status !== due.st || result_index !== due.idx
                        || read_data !== due.word)
                        flag_mismatch($sformatf(
                            "status exp %0d got %0d, index exp %0d got %0d, data exp %h got %h",
                            due.st, status, due.idx, result_index, due.word, read_data));
                end
            end
            if (in_valid === 1'b1 && in_stall === 1'b0)
                answers_due.push_back(table_answer(cmd_t'(command), key_hash,
                                                   entry_data, entry_index));
        end
    end

    // Result side: random stalls, quiet stretches and one long hold-off
    initial
    begin : result_sink
        int gap;
        out_stall = 1'b1;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                gap = HOLD_CYCLES;
            end
            else if (receiver_quiet)
                gap = 0;
            else
                gap = $urandom_range(0, 4);
            if (gap != 0)
            begin
                out_stall <= 1'b1;
                repeat (gap) @(negedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!(out_valid === 1'b1 && out_stall === 1'b0));
            @(negedge clk);
        end
    end

    // Starts and ends at a falling edge; valid stays high once the beat is taken
    task automatic send_item(input cmd_t op, input logic [63:0] key,
                             input logic [63:0] word, input logic [7:0] idx);
        int gap;
        gap = sender_quiet ? 0 : $urandom_range(0, 4);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid    <= 1'b1;
        command     <= op;
        key_hash    <= key;
        entry_data  <= word;
        entry_index <= idx;
        do @(posedge clk); while (!(in_valid === 1'b1 && in_stall === 1'b0));
        @(negedge clk);
    endtask

    function automatic logic [63:0] pick_key();
        case ($urandom_range(0, 3))
            0, 1: return {$urandom, $urandom};
            2:
            begin
                if (seen_keys.size() != 0)
                    return seen_keys[$urandom_range(0, seen_keys.size() - 1)];
                return {$urandom, $urandom};
            end
            default:
            begin
                case ($urandom_range(0, 4))
                    0: return KEY_MIN;
                    1: return KEY_MAX;
                    2: return ALL_ONES;
                    3: return '0;
                    default: return 64'($urandom_range(1, 7));
                endcase
            end
        endcase
    endfunction

    task automatic send_random_item(input int clear_pct);
        int          pick;
        cmd_t        op;
        logic [63:0] key;
        logic [63:0] word;
        logic [7:0]  idx;
        pick = $urandom_range(0, 99);
        key  = pick_key();
        word = {$urandom, $urandom};
        idx  = 8'($urandom_range(0, 255));
        if (pick < clear_pct)
            op = CMD_CLEAR;
        else if (pick < clear_pct + 40)
        begin
            op = CMD_INSERT;
            if (seen_keys.size() < 512)
                seen_keys.push_back(key);
        end
        else if (pick < clear_pct + 70)
        begin
            op = CMD_FIND;
            if (table_count != 0 && $urandom_range(0, 9) < 6)
                key = key_table[8'($urandom_range(0, table_count - 1))];
        end
        else
        begin
            op = CMD_READ;
            if (table_count != 0 && $urandom_range(0, 3) != 0)
                idx = 8'($urandom_range(0, table_count - 1));
        end
        send_item(op, key, word, idx);
    endtask

    task automatic test_empty_table();
        send_item(CMD_FIND, {$urandom, $urandom}, '0, '0);
        send_item(CMD_READ, '0, ALL_ONES, 8'd0);
        send_item(CMD_READ, '0, '0, 8'd255);
        send_item(CMD_CLEAR, ALL_ONES, ALL_ONES, 8'd255);
    endtask

    task automatic test_extreme_fields();
        send_item(CMD_INSERT, KEY_MIN, '0, 8'd255);
        send_item(CMD_INSERT, KEY_MAX, ALL_ONES, 8'd0);
        send_item(CMD_INSERT, '0, 64'h5555_5555_5555_5555, 8'd170);
        send_item(CMD_INSERT, ALL_ONES, 64'hAAAA_AAAA_AAAA_AAAA, 8'd85);
        // duplicate key: find must return the first copy
        send_item(CMD_INSERT, KEY_MAX, 64'h0123_4567_89AB_CDEF, 8'd1);
        send_item(CMD_FIND, KEY_MAX, '0, '0);
        send_item(CMD_FIND, KEY_MIN, '0, '0);
        send_item(CMD_FIND, ALL_ONES, '0, '0);
        send_item(CMD_FIND, '0, '0, '0);
        send_item(CMD_FIND, 64'h1, '0, '0);
        send_item(CMD_READ, '0, '0, 8'd0);
        send_item(CMD_READ, '0, '0, 8'd1);
        send_item(CMD_READ, '0, '0, 8'd3);
        send_item(CMD_READ, '0, '0, 8'd4);
        send_item(CMD_READ, '0, '0, 8'd5);
        send_item(CMD_READ, '0, '0, 8'd255);
        send_item(CMD_CLEAR, '0, '0, '0);
        send_item(CMD_READ, '0, '0, 8'd0);
        send_item(CMD_FIND, KEY_MAX, '0, '0);
    endtask

    task automatic test_fill_to_capacity();
        logic [63:0] last_key;
        for (int n = 0; n < TABLE_SIZE; n++)
        begin
            last_key = {$urandom, $urandom};
            send_item(CMD_INSERT, last_key, {$urandom, $urandom}, 8'($urandom_range(0, 255)));
        end
        send_item(CMD_INSERT, {$urandom, $urandom}, {$urandom, $urandom}, '0);
        send_item(CMD_FIND, last_key, '0, '0);
        send_item(CMD_READ, '0, '0, 8'd255);
        send_item(CMD_READ, '0, '0, 8'd0);
        send_item(CMD_CLEAR, '0, '0, '0);
    endtask

    // Hold the result side long enough that the unit stalls its input
    task automatic test_output_backpressure();
        hold_req = 1'b1;
        repeat (8) send_random_item(5);
    endtask

    task automatic test_random_traffic(input int count, input int clear_pct, input bit quiet);
        sender_quiet   = quiet;
        receiver_quiet = quiet;
        repeat (count) send_random_item(clear_pct);
        sender_quiet   = 1'b0;
        receiver_quiet = 1'b0;
    endtask

    task automatic test_near_full_traffic();
        send_item(CMD_CLEAR, '0, '0, '0);
        repeat (TABLE_SIZE - 6)
            send_item(CMD_INSERT, pick_key(), {$urandom, $urandom}, 8'($urandom_range(0, 255)));
        repeat (200) send_random_item(0);
    endtask

    initial
    begin : run_tests
        int waited;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        command     = CMD_INSERT;
        key_hash    = '0;
        entry_data  = '0;
        entry_index = '0;
        table_count = '0;
        bad_beats   = 0;
        hold_req    = 1'b0;
        sender_quiet   = 1'b0;
        receiver_quiet = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_empty_table();
        test_extreme_fields();
        test_fill_to_capacity();
        test_output_backpressure();
        test_random_traffic(700, 4, 1'b0);
        test_random_traffic(400, 3, 1'b1);
        test_near_full_traffic();

        in_valid <= 1'b0;
        waited = 0;
        while (answers_due.size() != 0 && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (TABLE_SIZE + 8) @(posedge clk);
        if (bad_beats == 0 && answers_due.size() == 0)
            $display("[hashed_symbol_table_unit] OK");
        else
            $display("[hashed_symbol_table_unit] ERROR");
        $finish;
    end

    initial
    begin : watchdog
        #(TIME_LIMIT);
        $display("[hashed_symbol_table_unit] ERROR");
        $finish;
    end

endmodule

### sim.f
rtl/hst_pkg.sv
rtl/hst_cell.sv
rtl/hashed_symbol_table_unit.sv
bench/tb_hashed_symbol_table_unit.sv
